/* src/humidity_temperature_conversion_defines.svh */
// ----------------------------------------------------------------------------
// Humidity / temperature conversion: assertion macros
// Shared assertion helpers, clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMPERATURE_CONVERSION_DEFINES_SVH
`define HUMIDITY_TEMPERATURE_CONVERSION_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define HTC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("htc: assertion failed");

// Consequent must hold in the cycle after the antecedent
`define HTC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("htc: assertion failed");

`endif

/* src/htc_pkg.sv */
// ----------------------------------------------------------------------------
// Humidity / temperature conversion package
// Microcode word format, datapath widths, coefficient tables and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package htc_pkg;

   // Datapath widths
   localparam int RAW_W  = 16;
   localparam int VAL_W  = 16;
   localparam int A_W    = 17;              // small multiplier operand
   localparam int B_W    = 40;              // wide multiplier operand
   localparam int PROD_W = A_W + B_W;
   localparam int ACC_W  = 64;              // Q32 accumulator
   localparam int SQ_W   = 32;
   localparam int TSUM_W = 20;
   localparam int UPC_W  = 4;

   // Configuration register indexes
   localparam logic [1:0] CSR_VOLTAGE    = 2'd0;
   localparam logic [1:0] CSR_RESOLUTION = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD  = 2'd2;

   // Microprogram entry points
   localparam logic [UPC_W-1:0] UPC_IDLE = 4'd0;
   localparam logic [UPC_W-1:0] UPC_TEMP = 4'd1;
   localparam logic [UPC_W-1:0] UPC_HUM  = 4'd3;

   // Humidity constants in Q32; C1 is scaled by 100, TEMP_OFFSET is 25 C in hundredths
   localparam logic signed [ACC_W-1:0] C1_HUND = -64'sd879093906100;
   localparam logic signed [B_W-1:0]   T1_Q32  = 40'sd42949673;
   localparam logic signed [A_W-1:0]   TEMP_OFFSET = 17'sd2500;
   localparam logic signed [ACC_W-1:0] RND_POS = 64'sh0000_0000_8000_0000;
   localparam logic signed [ACC_W-1:0] RND_NEG = 64'sh0000_0000_7FFF_FFFF;

   typedef enum logic [1:0] {
      MA_RAW,
      MA_SQ_LO,
      MA_SQ_HI,
      MA_TDIFF
   } mul_a_type;

   typedef enum logic [2:0] {
      MB_RAW,
      MB_T2,
      MB_C2H,
      MB_C3H,
      MB_TC,
      MB_D2
   } mul_b_type;

   typedef enum logic [2:0] {
      WB_NONE,
      WB_SQ,
      WB_TC,
      WB_ACC_LOAD,
      WB_ACC_ADD,
      WB_ACC_ADD_SH,
      WB_HUM_OUT,
      WB_TEMP_OUT
   } wb_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_END,
      SEQ_DISPATCH
   } seq_type;

   typedef struct packed {
      seq_type   seq;
      mul_a_type ma;
      mul_b_type mb;
      wb_type    wb;
   } uword_type;

   // Sequencer to datapath
   typedef struct packed {
      logic      accept;
      logic      advance;
      logic      emit;
      mul_a_type ma;
      mul_b_type mb;
      wb_type    wb;
   } cmd_type;

   // Datapath to sequencer
   typedef struct packed {
      logic out_hold;
   } stat_type;

   // Temperature offset D1 in hundredths; indexes 5 and above use the 2.5 V entry
   function automatic logic signed [VAL_W-1:0] d1_coef(input logic [2:0] vsel);
      logic signed [VAL_W-1:0] d1;
      case (vsel)
         3'd0:    d1 = -16'sd4010;
         3'd1:    d1 = -16'sd3980;
         3'd2:    d1 = -16'sd3970;
         3'd3:    d1 = -16'sd3966;
         3'd4:    d1 = -16'sd3960;
         default: d1 = -16'sd3940;
      endcase
      return d1;
   endfunction

   function automatic logic signed [B_W-1:0] d2_coef(input logic res);
      return res ? 40'sd4 : 40'sd1;
   endfunction

   function automatic logic signed [B_W-1:0] c2h_coef(input logic res);
      return res ? 40'sd252200479600 : 40'sd15762530000;
   endfunction

   function automatic logic signed [B_W-1:0] c3h_coef(input logic res);
      return res ? -40'sd175427900 : -40'sd685300;
   endfunction

   function automatic logic signed [B_W-1:0] t2_coef(input logic res);
      return res ? 40'sd5497558 : 40'sd343597;
   endfunction

   // Clamp to the signed 16-bit result range
   function automatic logic signed [VAL_W-1:0] sat16(input logic signed [31:0] x);
      logic signed [VAL_W-1:0] y;
      if (x > 32'sd32767) begin
         y = 16'sh7FFF;
      end else if (x < -32'sd32768) begin
         y = 16'sh8000;
      end else begin
         y = x[VAL_W-1:0];
      end
      return y;
   endfunction

endpackage

`default_nettype wire

/* src/htc_if.sv */
// ----------------------------------------------------------------------------
// Humidity / temperature conversion channels
// Valid/ready channels for reading items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface htc_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [15:0] raw_reading;

   modport source (output valid, output mode, output raw_reading, input ready);
   modport sink   (input valid, input mode, input raw_reading, output ready);
endinterface

interface htc_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [15:0] value;
   logic               updated;

   modport source (output valid, output kind, output value, output updated, input ready);
   modport sink   (input valid, input kind, input value, input updated, output ready);
endinterface

`default_nettype wire

/* src/humidity_temperature_conversion.sv */
// ----------------------------------------------------------------------------
// Humidity / temperature conversion
// Converts raw sensor words to hundredths of a degree C or of percent RH.
// ----------------------------------------------------------------------------
// One item is worked at a time by a microcoded sequencer driving a single
// shared 17x40-bit multiplier and a 64-bit Q32 accumulator. A temperature
// item runs one multiply and then its emit step before the block is ready
// again; a humidity item runs the six multiplies of the humidity program one
// after another through that multiplier, then an accumulate step and the
// rounding emit step. The result register lets a new item be accepted while
// a result still waits; an emit step stalls only if the previous result has
// not been taken.
`default_nettype none

module humidity_temperature_conversion (
   input  wire logic        clock,
   input  wire logic        reset,
   htc_req_if.sink          req_item,
   htc_rsp_if.source        rsp_item,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);

   htc_pkg::cmd_type  cmd;
   htc_pkg::stat_type stat;

   // Step control
   htc_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_item.valid),
      .req_mode  (req_item.mode),
      .req_ready (req_item.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Arithmetic, configuration and result register
   htc_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_item.mode),
      .req_raw_reading  (req_item.raw_reading),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_item.ready),
      .rsp_valid        (rsp_item.valid),
      .rsp_kind         (rsp_item.kind),
      .rsp_value        (rsp_item.value),
      .rsp_updated      (rsp_item.updated)
   );

endmodule

`default_nettype wire

/* src/htc_ucode_rom.sv */
// ----------------------------------------------------------------------------
// Humidity / temperature conversion microcode store
// Read-only control program: one control word per step.
// ----------------------------------------------------------------------------
`default_nettype none

module htc_ucode_rom (
   input  wire logic [htc_pkg::UPC_W-1:0] addr,
   output htc_pkg::uword_type             word
);

   // Product of step n is written back by the word of step n+1
   always_comb begin
      case (addr)
         // idle: wait for an item, branch on mode
         4'd0:  word = '{htc_pkg::SEQ_DISPATCH, htc_pkg::MA_RAW,   htc_pkg::MB_RAW,
                         htc_pkg::WB_NONE};
         // temperature: D2 * raw, then offset, check and emit
         4'd1:  word = '{htc_pkg::SEQ_NEXT,     htc_pkg::MA_RAW,   htc_pkg::MB_D2,
                         htc_pkg::WB_NONE};
         4'd2:  word = '{htc_pkg::SEQ_END,      htc_pkg::MA_RAW,   htc_pkg::MB_RAW,
                         htc_pkg::WB_TEMP_OUT};
         // humidity: raw^2
         4'd3:  word = '{htc_pkg::SEQ_NEXT,     htc_pkg::MA_RAW,   htc_pkg::MB_RAW,
                         htc_pkg::WB_NONE};
         // T2 * raw; store raw^2
         4'd4:  word = '{htc_pkg::SEQ_NEXT,     htc_pkg::MA_RAW,   htc_pkg::MB_T2,
                         htc_pkg::WB_SQ};
         // C2 * raw; compensation slope = T1 + T2 * raw
         4'd5:  word = '{htc_pkg::SEQ_NEXT,     htc_pkg::MA_RAW,   htc_pkg::MB_C2H,
                         htc_pkg::WB_TC};
         // C3 * raw^2 low half; acc = C1 + C2 * raw
         4'd6:  word = '{htc_pkg::SEQ_NEXT,     htc_pkg::MA_SQ_LO, htc_pkg::MB_C3H,
                         htc_pkg::WB_ACC_LOAD};
         // C3 * raw^2 high half
         4'd7:  word = '{htc_pkg::SEQ_NEXT,     htc_pkg::MA_SQ_HI, htc_pkg::MB_C3H,
                         htc_pkg::WB_ACC_ADD};
         // (T - 25) * slope; add high half shifted by 16
         4'd8:  word = '{htc_pkg::SEQ_NEXT,     htc_pkg::MA_TDIFF, htc_pkg::MB_TC,
                         htc_pkg::WB_ACC_ADD_SH};
         4'd9:  word = '{htc_pkg::SEQ_NEXT,     htc_pkg::MA_RAW,   htc_pkg::MB_RAW,
                         htc_pkg::WB_ACC_ADD};
         // round, saturate, emit
         4'd10: word = '{htc_pkg::SEQ_END,      htc_pkg::MA_RAW,   htc_pkg::MB_RAW,
                         htc_pkg::WB_HUM_OUT};
         default: word = '{htc_pkg::SEQ_END,    htc_pkg::MA_RAW,   htc_pkg::MB_RAW,
                           htc_pkg::WB_NONE};
      endcase
   end

endmodule

`default_nettype wire

/* src/htc_sequencer.sv */
// ----------------------------------------------------------------------------
// Humidity / temperature conversion sequencer
// Step counter over the microcode store, with dispatch on mode and stall.
// ----------------------------------------------------------------------------
`default_nettype none
`include "humidity_temperature_conversion_defines.svh"

module htc_sequencer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_mode,
   output logic                   req_ready,
   input  wire htc_pkg::stat_type stat,
   output htc_pkg::cmd_type       cmd
);

   logic [htc_pkg::UPC_W-1:0] upc_ff;
   logic [htc_pkg::UPC_W-1:0] upc_in;
   htc_pkg::uword_type        word;
   logic                      accept;
   logic                      emit;
   logic                      advance;

   htc_ucode_rom u_rom (
      .addr (upc_ff),
      .word (word)
   );

   // Handshake and stall: an emit step waits for the result register
   always_comb begin
      req_ready = (upc_ff == htc_pkg::UPC_IDLE);
      accept    = req_ready && req_valid;
      emit      = word.wb inside {htc_pkg::WB_HUM_OUT, htc_pkg::WB_TEMP_OUT};
      advance   = !(emit && stat.out_hold);
   end

   // Next step
   always_comb begin
      case (word.seq)
         htc_pkg::SEQ_DISPATCH: begin
            if (accept) begin
               upc_in = req_mode ? htc_pkg::UPC_HUM : htc_pkg::UPC_TEMP;
            end else begin
               upc_in = htc_pkg::UPC_IDLE;
            end
         end
         htc_pkg::SEQ_NEXT: upc_in = advance ? upc_ff + 1'b1 : upc_ff;
         htc_pkg::SEQ_END:  upc_in = advance ? htc_pkg::UPC_IDLE : upc_ff;
         default:           upc_in = htc_pkg::UPC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= htc_pkg::UPC_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   always_comb begin
      cmd.accept  = accept;
      cmd.advance = advance;
      cmd.emit    = emit;
      cmd.ma      = word.ma;
      cmd.mb      = word.mb;
      cmd.wb      = word.wb;
   end

   `HTC_ASSERT_NEXT(a_dispatch_entry, accept, upc_ff == htc_pkg::UPC_TEMP || upc_ff == htc_pkg::UPC_HUM)
   `HTC_ASSERT_NEXT(a_stall_holds_step, !advance, $stable(upc_ff))

endmodule

`default_nettype wire

/* src/htc_datapath.sv */
// ----------------------------------------------------------------------------
// Humidity / temperature conversion datapath
// Shared 17x40 multiplier, Q32 accumulator, stored temperature, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "humidity_temperature_conversion_defines.svh"

module htc_datapath (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire htc_pkg::cmd_type          cmd,
   output htc_pkg::stat_type              stat,
   input  wire logic                      req_mode,
   input  wire logic [htc_pkg::RAW_W-1:0] req_raw_reading,
   input  wire logic                      csr_write_enable,
   input  wire logic [1:0]                csr_index,
   input  wire logic [15:0]               csr_write_data,
   input  wire logic                      rsp_ready,
   output logic                           rsp_valid,
   output logic                           rsp_kind,
   output logic signed [htc_pkg::VAL_W-1:0] rsp_value,
   output logic                           rsp_updated
);

   // Configuration and state
   logic [2:0]                          vsel_ff;
   logic                                res_ff;
   logic [htc_pkg::RAW_W-1:0]           thr_ff;
   logic signed [htc_pkg::VAL_W-1:0]    last_temp_ff;
   logic signed [htc_pkg::VAL_W-1:0]    last_temp_in;

   // Item and working registers
   logic                                mode_ff;
   logic [htc_pkg::RAW_W-1:0]           raw_ff;
   logic signed [htc_pkg::PROD_W-1:0]   prod_ff;
   logic signed [htc_pkg::PROD_W-1:0]   prod_in;
   logic [htc_pkg::SQ_W-1:0]            sq_ff;
   logic signed [htc_pkg::B_W-1:0]      tc_ff;
   logic signed [htc_pkg::ACC_W-1:0]    acc_ff;
   logic signed [htc_pkg::ACC_W-1:0]    acc_in;

   // Result register
   logic                                rsp_valid_ff;
   logic                                rsp_kind_ff;
   logic signed [htc_pkg::VAL_W-1:0]    rsp_value_ff;
   logic signed [htc_pkg::VAL_W-1:0]    rsp_value_in;
   logic                                rsp_updated_ff;
   logic                                rsp_updated_in;

   logic signed [htc_pkg::A_W-1:0]      tdiff;
   logic signed [htc_pkg::A_W-1:0]      a_op;
   logic signed [htc_pkg::B_W-1:0]      b_op;
   logic signed [htc_pkg::ACC_W-1:0]    prod_ext;
   logic signed [htc_pkg::ACC_W-1:0]    acc_base;
   logic signed [htc_pkg::ACC_W-1:0]    acc_addend;
   logic signed [htc_pkg::ACC_W-1:0]    rnd_sum;
   logic signed [htc_pkg::TSUM_W-1:0]   tsum;
   logic signed [htc_pkg::VAL_W-1:0]    temp_sat;
   logic signed [htc_pkg::VAL_W-1:0]    hum_sat;
   logic                                temp_ok;

   // Multiplier operands
   always_comb begin
      tdiff = htc_pkg::A_W'(last_temp_ff) - htc_pkg::TEMP_OFFSET;
      case (cmd.ma)
         htc_pkg::MA_RAW:   a_op = signed'({1'b0, raw_ff});
         htc_pkg::MA_SQ_LO: a_op = signed'({1'b0, sq_ff[15:0]});
         htc_pkg::MA_SQ_HI: a_op = signed'({1'b0, sq_ff[31:16]});
         htc_pkg::MA_TDIFF: a_op = tdiff;
         default:           a_op = '0;
      endcase
      case (cmd.mb)
         htc_pkg::MB_RAW: b_op = signed'({{(htc_pkg::B_W-htc_pkg::RAW_W){1'b0}}, raw_ff});
         htc_pkg::MB_T2:  b_op = htc_pkg::t2_coef(res_ff);
         htc_pkg::MB_C2H: b_op = htc_pkg::c2h_coef(res_ff);
         htc_pkg::MB_C3H: b_op = htc_pkg::c3h_coef(res_ff);
         htc_pkg::MB_TC:  b_op = tc_ff;
         htc_pkg::MB_D2:  b_op = htc_pkg::d2_coef(res_ff);
         default:         b_op = '0;
      endcase
      prod_in = a_op * b_op;
   end

   // Accumulator add
   always_comb begin
      prod_ext   = htc_pkg::ACC_W'(prod_ff);
      acc_base   = acc_ff;
      acc_addend = prod_ext;
      case (cmd.wb)
         htc_pkg::WB_ACC_LOAD:   acc_base   = htc_pkg::C1_HUND;
         htc_pkg::WB_ACC_ADD_SH: acc_addend = prod_ext <<< 16;
         default:                acc_addend = prod_ext;
      endcase
      acc_in = acc_base + acc_addend;
   end

   // Humidity: round halves away from zero, then drop the fraction
   always_comb begin
      rnd_sum = acc_ff + (acc_ff[htc_pkg::ACC_W-1] ? htc_pkg::RND_NEG : htc_pkg::RND_POS);
      hum_sat = htc_pkg::sat16(rnd_sum[63:32]);
   end

   // Temperature: D1 + D2 * raw, accepted only above the threshold
   always_comb begin
      tsum     = signed'(prod_ff[htc_pkg::TSUM_W-1:0])
                 + htc_pkg::TSUM_W'(htc_pkg::d1_coef(vsel_ff));
      temp_sat = htc_pkg::sat16(32'(tsum));
      temp_ok  = raw_ff > thr_ff;
   end

   // Result selection
   always_comb begin
      last_temp_in   = last_temp_ff;
      rsp_value_in   = hum_sat;
      rsp_updated_in = 1'b1;
      if (cmd.wb == htc_pkg::WB_TEMP_OUT) begin
         if (temp_ok) begin
            last_temp_in = temp_sat;
            rsp_value_in = temp_sat;
         end else begin
            rsp_value_in   = last_temp_ff;
            rsp_updated_in = 1'b0;
         end
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vsel_ff      <= '0;
         res_ff       <= 1'b0;
         thr_ff       <= '0;
         last_temp_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               htc_pkg::CSR_VOLTAGE:    vsel_ff <= csr_write_data[2:0];
               htc_pkg::CSR_RESOLUTION: res_ff  <= csr_write_data[0];
               htc_pkg::CSR_THRESHOLD:  thr_ff  <= csr_write_data;
               default: ;
            endcase
         end
         if (cmd.advance && cmd.wb == htc_pkg::WB_TEMP_OUT) begin
            last_temp_ff <= last_temp_in;
         end
         if (cmd.advance && cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff <= req_mode;
         raw_ff  <= req_raw_reading;
      end
      if (cmd.advance) begin
         prod_ff <= prod_in;
         case (cmd.wb)
            htc_pkg::WB_SQ: sq_ff <= prod_ff[htc_pkg::SQ_W-1:0];
            htc_pkg::WB_TC: tc_ff <= prod_ff[htc_pkg::B_W-1:0] + htc_pkg::T1_Q32;
            htc_pkg::WB_ACC_LOAD, htc_pkg::WB_ACC_ADD, htc_pkg::WB_ACC_ADD_SH: begin
               acc_ff <= acc_in;
            end
            htc_pkg::WB_HUM_OUT, htc_pkg::WB_TEMP_OUT: begin
               rsp_kind_ff    <= mode_ff;
               rsp_value_ff   <= rsp_value_in;
               rsp_updated_ff <= rsp_updated_in;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      stat.out_hold = rsp_valid_ff && !rsp_ready;
      rsp_valid     = rsp_valid_ff;
      rsp_kind      = rsp_kind_ff;
      rsp_value     = rsp_value_ff;
      rsp_updated   = rsp_updated_ff;
   end

   `HTC_ASSERT_NEXT(a_emit_sets_valid, cmd.advance && cmd.emit, rsp_valid_ff)
   `HTC_ASSERT_NEXT(a_reject_keeps_temp, cmd.advance && cmd.wb == htc_pkg::WB_TEMP_OUT && !temp_ok, $stable(last_temp_ff))

endmodule

`default_nettype wire
